[hw/rtl/abl_pkg.sv]
package abl_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int CRC_W         = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CRC_W-1:0] POLY_RESET = 8'h1D;
  localparam logic             PIGGY_RESET = 1'b0;

  // Configuration register indexes.
  localparam logic REG_POLY  = 1'b0;
  localparam logic REG_PIGGY = 1'b1;

  // Command codes.
  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_TIMER = 2'd2;

  // Frame kinds.
  localparam logic [1:0] FT_DATA  = 2'd0;
  localparam logic [1:0] FT_ACK   = 2'd1;
  localparam logic [1:0] FT_PIGGY = 2'd2;

  typedef enum logic [2:0] {
    K_SEND,
    K_DATA,
    K_ACK,
    K_PIGGY,
    K_TIMER,
    K_UNKNOWN
  } kind_t;

  typedef enum logic [3:0] {
    ST_SENT          = 4'd0,
    ST_BUSY_DROP     = 4'd1,
    ST_ACK_OK        = 4'd2,
    ST_ACK_UNNEEDED  = 4'd3,
    ST_CORRUPT       = 4'd4,
    ST_BAD_ACK       = 4'd5,
    ST_BAD_SEQ       = 4'd6,
    ST_DELIVERED     = 4'd7,
    ST_RESENT        = 4'd8,
    ST_TIMER_IGNORED = 4'd9,
    ST_UNKNOWN       = 4'd10
  } status_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    kind_t                kind;
    logic                 bad;
    logic                 seq_small;
    logic                 seq_bit;
    logic                 ack_small;
    logic                 ack_bit;
    logic [CRC_W-1:0]     crc_pay;
    logic [PAYLOAD_W-1:0] payload;
  } item_t;

  typedef struct packed {
    logic [1:0]           ftype;
    logic                 seq;
    logic                 ack;
    logic [CRC_W-1:0]     crc;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

  typedef struct packed {
    logic                 tx_valid;
    frame_t               tx;
    logic                 deliver_valid;
    logic [PAYLOAD_W-1:0] deliver_payload;
    logic                 start_timer;
    logic                 stop_timer;
    status_t              status;
  } result_t;

  // One byte through an MSB-first CRC-8 register.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] data_byte,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc ^ data_byte;
    for (int j = 0; j < 8; j++) begin
      if (c[CRC_W-1]) begin
        c = (c << 1) ^ poly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  function automatic logic [CRC_W-1:0] crc_payload(input logic [PAYLOAD_W-1:0] payload,
                                                   input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = '0;
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      c = crc_feed(c, payload[i*8 +: 8], poly);
    end
    return c;
  endfunction

  // Seq, ack and type bytes that close every frame.
  function automatic logic [CRC_W-1:0] crc_tail(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] seq_byte,
                                                input logic [7:0] ack_byte,
                                                input logic [7:0] type_byte,
                                                input logic [CRC_W-1:0] poly);
    logic [CRC_W-1:0] c;
    c = crc_feed(crc, seq_byte, poly);
    c = crc_feed(c, ack_byte, poly);
    c = crc_feed(c, type_byte, poly);
    return c;
  endfunction

endpackage

[hw/rtl/abl_front.sv]
module abl_front (
  input  logic [1:0]                      command,
  input  logic [abl_pkg::PAYLOAD_W-1:0]   payload,
  input  logic [1:0]                      frame_type,
  input  logic [7:0]                      frame_seq,
  input  logic [7:0]                      frame_ack,
  input  logic [7:0]                      frame_crc,
  input  logic [abl_pkg::CRC_W-1:0]       poly,
  output abl_pkg::item_t                  item
);

  logic [abl_pkg::CRC_W-1:0] crc_pay;
  logic [abl_pkg::CRC_W-1:0] crc_rx;

  always_comb begin
    crc_pay = abl_pkg::crc_payload(payload, poly);
    crc_rx  = abl_pkg::crc_feed(
                abl_pkg::crc_tail(crc_pay, frame_seq, frame_ack, {6'b0, frame_type}, poly),
                frame_crc, poly);
  end

  always_comb begin
    item.kind = abl_pkg::K_UNKNOWN;
    unique case (command)
      abl_pkg::CMD_SEND:  item.kind = abl_pkg::K_SEND;
      abl_pkg::CMD_TIMER: item.kind = abl_pkg::K_TIMER;
      abl_pkg::CMD_FRAME: begin
        unique case (frame_type)
          abl_pkg::FT_DATA:  item.kind = abl_pkg::K_DATA;
          abl_pkg::FT_ACK:   item.kind = abl_pkg::K_ACK;
          abl_pkg::FT_PIGGY: item.kind = abl_pkg::K_PIGGY;
          default:           item.kind = abl_pkg::K_UNKNOWN;
        endcase
      end
      default: item.kind = abl_pkg::K_UNKNOWN;
    endcase
    // A good frame leaves a zero remainder once its check byte is fed in.
    item.bad       = (crc_rx != '0);
    item.seq_small = (frame_seq[7:1] == 7'd0);
    item.seq_bit   = frame_seq[0];
    item.ack_small = (frame_ack[7:1] == 7'd0);
    item.ack_bit   = frame_ack[0];
    item.crc_pay   = crc_pay;
    item.payload   = payload;
  end

endmodule

[hw/rtl/abl_queue.sv]
module abl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  abl_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output abl_pkg::item_t head_item
);

  abl_pkg::item_t                entries [abl_pkg::QUEUE_DEPTH];
  logic [abl_pkg::PTR_W-1:0]     wr_ptr;
  logic [abl_pkg::PTR_W-1:0]     rd_ptr;
  logic [abl_pkg::CNT_W-1:0]     count;

  function automatic logic [abl_pkg::PTR_W-1:0] ptr_inc(input logic [abl_pkg::PTR_W-1:0] p);
    return (p == abl_pkg::PTR_W'(abl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count == abl_pkg::CNT_W'(abl_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= abl_pkg::CNT_W'(abl_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty queue with unequal pointers");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from an empty queue");

endmodule

[hw/rtl/abl_back.sv]
module abl_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  abl_pkg::item_t            head_item,
  output logic                      pop,
  input  logic [abl_pkg::CRC_W-1:0] poly,
  input  logic                      piggy_en,
  output logic                      out_valid,
  input  logic                      out_stall,
  output abl_pkg::result_t          result
);

  logic            awaiting_ack;
  logic            send_seq;
  logic            recv_seq;
  logic            ack_pending;
  logic            held_ack;
  abl_pkg::frame_t saved_frame;

  logic            awaiting_ack_next;
  logic            send_seq_next;
  logic            recv_seq_next;
  logic            ack_pending_next;
  logic            held_ack_next;

  abl_pkg::result_t res;
  abl_pkg::frame_t  send_frame;
  logic             do_ack;
  logic             ack_value;
  logic             ack_bit_sent;
  logic             seq_match;
  logic             ack_match;

  assign pop = head_valid && (!out_valid || !out_stall);

  always_comb begin
    awaiting_ack_next = awaiting_ack;
    send_seq_next     = send_seq;
    recv_seq_next     = recv_seq;
    ack_pending_next  = ack_pending;
    held_ack_next     = held_ack;
    res               = '0;
    res.status        = abl_pkg::ST_UNKNOWN;
    do_ack            = 1'b0;
    ack_value         = 1'b0;

    seq_match = head_item.seq_small && (head_item.seq_bit == recv_seq);
    ack_match = head_item.ack_small && (head_item.ack_bit == send_seq);

    send_frame.ftype   = (piggy_en && ack_pending) ? abl_pkg::FT_PIGGY : abl_pkg::FT_DATA;
    send_frame.seq     = send_seq;
    send_frame.ack     = held_ack;
    send_frame.payload = head_item.payload;
    send_frame.crc     = abl_pkg::crc_tail(head_item.crc_pay, {7'b0, send_seq},
                                           {7'b0, held_ack}, {6'b0, send_frame.ftype}, poly);

    unique case (head_item.kind)
      abl_pkg::K_SEND: begin
        if (awaiting_ack) begin
          res.status = abl_pkg::ST_BUSY_DROP;
        end else begin
          res.tx_valid      = 1'b1;
          res.tx            = send_frame;
          res.start_timer   = 1'b1;
          res.status        = abl_pkg::ST_SENT;
          awaiting_ack_next = 1'b1;
          ack_pending_next  = 1'b0;
        end
      end
      abl_pkg::K_ACK: begin
        if (!awaiting_ack) begin
          res.status = abl_pkg::ST_ACK_UNNEEDED;
        end else if (head_item.bad) begin
          res.status = abl_pkg::ST_CORRUPT;
        end else if (!ack_match) begin
          res.status = abl_pkg::ST_BAD_ACK;
        end else begin
          res.stop_timer    = 1'b1;
          res.status        = abl_pkg::ST_ACK_OK;
          send_seq_next     = ~send_seq;
          awaiting_ack_next = 1'b0;
        end
      end
      abl_pkg::K_DATA, abl_pkg::K_PIGGY: begin
        if (head_item.bad) begin
          do_ack     = 1'b1;
          ack_value  = ~recv_seq;
          res.status = abl_pkg::ST_CORRUPT;
        end else if (!seq_match) begin
          do_ack     = 1'b1;
          ack_value  = ~recv_seq;
          res.status = abl_pkg::ST_BAD_SEQ;
        end else if (head_item.kind == abl_pkg::K_PIGGY && !ack_match) begin
          res.status = abl_pkg::ST_BAD_ACK;
        end else begin
          if (head_item.kind == abl_pkg::K_PIGGY) begin
            res.stop_timer    = 1'b1;
            send_seq_next     = ~send_seq;
            awaiting_ack_next = 1'b0;
          end
          do_ack              = 1'b1;
          ack_value           = recv_seq;
          res.deliver_valid   = 1'b1;
          res.deliver_payload = head_item.payload;
          recv_seq_next       = ~recv_seq;
          res.status          = abl_pkg::ST_DELIVERED;
        end
      end
      abl_pkg::K_TIMER: begin
        if (!awaiting_ack) begin
          res.status = abl_pkg::ST_TIMER_IGNORED;
        end else begin
          res.tx_valid    = 1'b1;
          res.tx          = saved_frame;
          res.start_timer = 1'b1;
          res.status      = abl_pkg::ST_RESENT;
        end
      end
      default: res.status = abl_pkg::ST_UNKNOWN;
    endcase

    // With piggybacking on, the first acknowledgement is held for the next
    // data frame; otherwise a standalone ack frame goes out right away.
    ack_bit_sent = piggy_en ? held_ack : ack_value;
    if (do_ack) begin
      if (piggy_en && !ack_pending) begin
        held_ack_next    = ack_value;
        ack_pending_next = 1'b1;
      end else begin
        res.tx_valid   = 1'b1;
        res.tx.ftype   = abl_pkg::FT_ACK;
        res.tx.seq     = recv_seq;
        res.tx.ack     = ack_bit_sent;
        res.tx.payload = '0;
        res.tx.crc     = abl_pkg::crc_tail('0, {7'b0, recv_seq}, {7'b0, ack_bit_sent},
                                           {6'b0, abl_pkg::FT_ACK}, poly);
        ack_pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_ack <= 1'b0;
      send_seq     <= 1'b0;
      recv_seq     <= 1'b0;
      ack_pending  <= 1'b0;
      held_ack     <= 1'b0;
      out_valid    <= 1'b0;
    end else if (pop) begin
      awaiting_ack <= awaiting_ack_next;
      send_seq     <= send_seq_next;
      recv_seq     <= recv_seq_next;
      ack_pending  <= ack_pending_next;
      held_ack     <= held_ack_next;
      out_valid    <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
      if (head_item.kind == abl_pkg::K_SEND && !awaiting_ack) begin
        saved_frame <= send_frame;
      end
    end
  end

  a_timer_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result.start_timer && result.stop_timer))
    else $error("timer start and stop in one result");

  a_deliver_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.deliver_valid) |-> (result.status == abl_pkg::ST_DELIVERED))
    else $error("delivery without delivered status");

  a_sent_waits: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.status == abl_pkg::ST_SENT) |-> (awaiting_ack && result.tx_valid))
    else $error("sent frame without waiting for its ack");

  a_ack_ok_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.status == abl_pkg::ST_ACK_OK) |-> !awaiting_ack)
    else $error("accepted ack left the sender waiting");

endmodule

[hw/rtl/alternating_bit_link_entity_core.sv]
// Alternating-bit link endpoint: one result for every accepted item.
// A result is registered after its input transfer: the transfer edge writes the
// classify queue, and the pop edge, with the output free, runs the protocol state.
// Throughput: one item per cycle without out_stall; the CRC is an unrolled XOR network.
// Reset clears the protocol state and the queue, sets the polynomial to
// 0x1D and piggybacking off; the saved frame is written by the first send.
module alternating_bit_link_entity_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic                             cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       command,
  input  logic [abl_pkg::PAYLOAD_W-1:0]    payload,
  input  logic [1:0]                       frame_type,
  input  logic [7:0]                       frame_seq,
  input  logic [7:0]                       frame_ack,
  input  logic [7:0]                       frame_crc,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             tx_valid,
  output logic [1:0]                       tx_type,
  output logic                             tx_seq,
  output logic                             tx_ack,
  output logic [7:0]                       tx_crc,
  output logic [abl_pkg::PAYLOAD_W-1:0]    tx_payload,
  output logic                             deliver_valid,
  output logic [abl_pkg::PAYLOAD_W-1:0]    deliver_payload,
  output logic                             start_timer,
  output logic                             stop_timer,
  output logic [3:0]                       status
);

  logic [abl_pkg::CRC_W-1:0] crc_polynomial;
  logic                      piggyback_enable;

  abl_pkg::item_t   front_item;
  abl_pkg::item_t   head_item;
  abl_pkg::result_t result;
  logic             queue_full;
  logic             head_valid;
  logic             pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial   <= abl_pkg::POLY_RESET;
      piggyback_enable <= abl_pkg::PIGGY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        abl_pkg::REG_POLY:  crc_polynomial   <= cfg_data;
        abl_pkg::REG_PIGGY: piggyback_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = queue_full;

  abl_front u_front (
    .command    (command),
    .payload    (payload),
    .frame_type (frame_type),
    .frame_seq  (frame_seq),
    .frame_ack  (frame_ack),
    .frame_crc  (frame_crc),
    .poly       (crc_polynomial),
    .item       (front_item)
  );

  abl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !queue_full),
    .push_item  (front_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  abl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .poly       (crc_polynomial),
    .piggy_en   (piggyback_enable),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign tx_valid        = result.tx_valid;
  assign tx_type         = result.tx.ftype;
  assign tx_seq          = result.tx.seq;
  assign tx_ack          = result.tx.ack;
  assign tx_crc          = result.tx.crc;
  assign tx_payload      = result.tx.payload;
  assign deliver_valid   = result.deliver_valid;
  assign deliver_payload = result.deliver_payload;
  assign start_timer     = result.start_timer;
  assign stop_timer      = result.stop_timer;
  assign status          = result.status;

endmodule
